[hdl/kved_pkg.sv]
// ----------------------------------------------------------------------------
// kved_pkg
// Types, constants and helpers shared by the key/value escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package kved_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CfgIdxW = 2;

  // result queue depth; two slots are kept free for the widest input beat
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned MaxRes  = 2;

  localparam logic [ByteW-1:0] KeySepRst  = 8'd61;  // '='
  localparam logic [ByteW-1:0] PairSepRst = 8'd59;  // ';'
  localparam logic [ByteW-1:0] EscRst     = 8'd92;  // backslash

  localparam logic [ByteW-1:0] ChEnd   = 8'd0;
  localparam logic [ByteW-1:0] ChHex   = 8'd120;  // 'x'
  localparam logic [ByteW-1:0] ChN     = 8'd110;
  localparam logic [ByteW-1:0] ChR     = 8'd114;
  localparam logic [ByteW-1:0] ChT     = 8'd116;
  localparam logic [ByteW-1:0] ChZero  = 8'd48;   // '0'
  localparam logic [ByteW-1:0] ChNine  = 8'd57;
  localparam logic [ByteW-1:0] ChLa    = 8'd97;
  localparam logic [ByteW-1:0] ChLf    = 8'd102;
  localparam logic [ByteW-1:0] ChUa    = 8'd65;
  localparam logic [ByteW-1:0] ChUf    = 8'd70;
  localparam logic [ByteW-1:0] ByteAll = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_SEP  = 2'd0,
    REG_PAIR_SEP = 2'd1,
    REG_ESC      = 2'd2
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA        = 3'd0,
    KIND_KEY_DONE    = 3'd1,
    KIND_PAIR_DONE   = 3'd2,
    KIND_RECORD_DONE = 3'd3,
    KIND_ERROR       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_START = 2'd1,
    ESC_HI    = 2'd2,
    ESC_LO    = 2'd3
  } esc_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             in_value;
    logic             last;
  } res_t;

  // results of one input beat
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic res_t mk_res(kind_e kind, logic [ByteW-1:0] data,
                                  logic in_value, logic last);
    res_t r;
    r.kind     = kind;
    r.data     = (kind == KIND_DATA) ? data : '0;
    r.in_value = (kind == KIND_DATA) ? in_value : 1'b0;
    r.last     = last;
    return r;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(logic [ByteW-1:0] c);
    logic [4:0] v;
    logic [ByteW-1:0] t;
    v = 5'h0F;
    t = '0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      v = {1'b1, t[3:0]};
    end else if (c >= ChLa && c <= ChLf) begin
      t = c - ChLa + 8'd10;
      v = {1'b1, t[3:0]};
    end else if (c >= ChUa && c <= ChUf) begin
      t = c - ChUa + 8'd10;
      v = {1'b1, t[3:0]};
    end
    return v;
  endfunction

  function automatic logic [ByteW-1:0] simple_unesc(logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c == ChN) r = 8'd10;
    else if (c == ChR) r = 8'd13;
    else if (c == ChT) r = 8'd9;
    else if (c == ChZero) r = 8'd0;
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/key_value_escape_decoder_unit.sv]
// ----------------------------------------------------------------------------
// key_value_escape_decoder_unit
// Escaped key=value;key=value record decoder, one encoded byte per beat.
// ----------------------------------------------------------------------------
// Input stream: one encoded byte per beat on s_axis_tdata; byte 0 ends a record.
// Output stream: decoded results; tuser carries the kind (data, key done,
// pair done, record done, error), tdata the decoded byte and the value flag,
// tlast marks the last result caused by one input byte.
// A byte accepted at one edge into an empty queue has its first result on the
// output right after that edge. One byte is taken every cycle while the queue
// has room; an end of record in a value gives two results, so a long burst of
// those is limited by the single output beat per cycle.
// A four-entry result queue sits between parser and output; input is taken
// while two entries are free, so with a stalled receiver the input is held
// back as soon as three results wait, and nothing is lost.
// Reset clears the queue and parser state and loads the default separators
// '=' ';' and escape '\'. Config writes (cfg_we_i) take effect the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_escape_decoder_unit import kved_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] in_byte
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // [7:0] out_byte, [8] out_in_value
  output logic [KindW-1:0]        m_axis_tuser,   // [2:0] out_kind
  output logic                    m_axis_tlast    // out_last
);

  logic      beat;
  res_pair_t res;
  res_t      head;

  assign beat = s_axis_tvalid && s_axis_tready;

  kved_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .beat_i     (beat),
    .byte_i     (s_axis_tdata),
    .res_o      (res)
  );

  kved_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (beat),
    .res_i   (res),
    .pop_i   (m_axis_tready),
    .space_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  assign m_axis_tdata = {7'd0, head.in_value, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // only pair done ahead of record done can be a non-final result
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_PAIR_DONE |-> m_axis_tlast)
    else $error("non-final result of unexpected kind");

  a_ctrl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata == 16'd0)
    else $error("control result carries data");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_ERROR)
    else $error("result kind out of range");

  // a non-final pair done is always followed by its record done
  a_pair_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
      |=> m_axis_tvalid && m_axis_tuser == KIND_RECORD_DONE)
    else $error("pair done not followed by record done");

  a_two_res_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && res.num == 2'd2 |-> s_axis_tdata == ChEnd)
    else $error("two results from a non-terminating byte");

endmodule

`default_nettype wire

[hdl/kved_parse.sv]
// ----------------------------------------------------------------------------
// kved_parse
// Config registers, parser state and per-beat decode into up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module kved_parse import kved_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic               beat_i,
  input  wire logic [ByteW-1:0]   byte_i,
  output res_pair_t               res_o
);

  logic [ByteW-1:0] key_sep_q, pair_sep_q, esc_q;
  logic             in_val_q, in_val_d;
  logic             pstart_q, pstart_d;
  esc_e             esc_step_q, esc_step_d;
  logic [3:0]       hi_q, hi_d;
  logic             rej_q, rej_d;
  logic [4:0]       hx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_sep_q  <= KeySepRst;
      pair_sep_q <= PairSepRst;
      esc_q      <= EscRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_SEP:  key_sep_q  <= cfg_data_i;
        REG_PAIR_SEP: pair_sep_q <= cfg_data_i;
        REG_ESC:      esc_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_val_q   <= 1'b0;
      pstart_q   <= 1'b1;
      esc_step_q <= ESC_NONE;
      hi_q       <= '0;
      rej_q      <= 1'b0;
    end else if (beat_i) begin
      in_val_q   <= in_val_d;
      pstart_q   <= pstart_d;
      esc_step_q <= esc_step_d;
      hi_q       <= hi_d;
      rej_q      <= rej_d;
    end
  end

  assign hx = hex_val(byte_i);

  always_comb begin
    in_val_d   = in_val_q;
    pstart_d   = pstart_q;
    esc_step_d = esc_step_q;
    hi_d       = hi_q;
    rej_d      = rej_q;
    res_o.num  = 2'd0;
    res_o.r0   = mk_res(KIND_DATA, byte_i, in_val_q, 1'b1);
    res_o.r1   = mk_res(KIND_RECORD_DONE, '0, 1'b0, 1'b1);

    if (rej_q) begin
      if (byte_i == ChEnd) begin
        in_val_d   = 1'b0;
        pstart_d   = 1'b1;
        esc_step_d = ESC_NONE;
        hi_d       = '0;
        rej_d      = 1'b0;
      end
    end else if (byte_i == ChEnd) begin
      // end of record: any partial escape is dropped
      res_o.num = 2'd1;
      if (in_val_q) begin
        res_o.num = 2'd2;
        res_o.r0  = mk_res(KIND_PAIR_DONE, '0, 1'b0, 1'b0);
      end else if (pstart_q) begin
        res_o.r0  = mk_res(KIND_RECORD_DONE, '0, 1'b0, 1'b1);
      end else begin
        res_o.r0  = mk_res(KIND_ERROR, '0, 1'b0, 1'b1);
      end
      in_val_d   = 1'b0;
      pstart_d   = 1'b1;
      esc_step_d = ESC_NONE;
      hi_d       = '0;
      rej_d      = 1'b0;
    end else begin
      unique case (esc_step_q)
        ESC_START: begin
          if (byte_i == ChHex) begin
            esc_step_d = ESC_HI;
          end else begin
            esc_step_d = ESC_NONE;
            res_o.num  = 2'd1;
            res_o.r0   = mk_res(KIND_DATA, simple_unesc(byte_i), in_val_q, 1'b1);
          end
        end
        ESC_HI: begin
          hi_d       = hx[3:0];
          esc_step_d = ESC_LO;
        end
        ESC_LO: begin
          esc_step_d = ESC_NONE;
          res_o.num  = 2'd1;
          res_o.r0   = mk_res(KIND_DATA, hx[4] ? {hi_q, hx[3:0]} : ByteAll,
                              in_val_q, 1'b1);
        end
        ESC_NONE: begin
          if (!in_val_q) begin
            pstart_d = 1'b0;
            if (byte_i == pair_sep_q) begin
              res_o.num = 2'd1;
              res_o.r0  = mk_res(KIND_ERROR, '0, 1'b0, 1'b1);
              rej_d     = 1'b1;
            end else if (byte_i == key_sep_q) begin
              in_val_d  = 1'b1;
              res_o.num = 2'd1;
              res_o.r0  = mk_res(KIND_KEY_DONE, '0, 1'b0, 1'b1);
            end else if (byte_i == esc_q) begin
              esc_step_d = ESC_START;
            end else begin
              res_o.num = 2'd1;
              res_o.r0  = mk_res(KIND_DATA, byte_i, 1'b0, 1'b1);
            end
          end else begin
            if (byte_i == key_sep_q) begin
              res_o.num = 2'd1;
              res_o.r0  = mk_res(KIND_ERROR, '0, 1'b0, 1'b1);
              rej_d     = 1'b1;
            end else if (byte_i == pair_sep_q) begin
              in_val_d  = 1'b0;
              pstart_d  = 1'b1;
              res_o.num = 2'd1;
              res_o.r0  = mk_res(KIND_PAIR_DONE, '0, 1'b0, 1'b1);
            end else if (byte_i == esc_q) begin
              esc_step_d = ESC_START;
            end else begin
              res_o.num = 2'd1;
              res_o.r0  = mk_res(KIND_DATA, byte_i, 1'b1, 1'b1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/kved_resq.sv]
// ----------------------------------------------------------------------------
// kved_resq
// Small result queue: takes up to two results per cycle, emits one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kved_resq import kved_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire res_pair_t res_i,
  input  wire logic      pop_i,
  output logic           space_o,
  output logic           valid_o,
  output res_t           head_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [1:0]       n_push;
  logic             do_pop;

  assign n_push  = push_i ? res_i.num : 2'd0;
  assign do_pop  = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign space_o = (cnt_q <= QCntW'(QDepth - MaxRes));
  assign wr_nx   = wr_q + QPtrW'(1);

  assign wr_d  = wr_q + QPtrW'(n_push);
  assign rd_d  = rd_q + QPtrW'(do_pop);
  assign cnt_d = cnt_q + QCntW'(n_push) - QCntW'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= res_i.r0;
    if (n_push == 2'd2) mem_q[wr_nx] <= res_i.r1;
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams escaped key=value records into key_value_escape_decoder_unit and
// checks every output beat against an in-bench decoder. A short directed
// record set comes first. Random well-formed and broken records follow under
// several separator/escape settings. Both streams stall at random, and one
// long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------

module testbench;
  import kved_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       in_value;
    logic       last;
  } dec_res_t;

  localparam logic [7:0] EndByte    = 8'd0;
  localparam logic [7:0] HexIntro   = "x";
  localparam int         HoldCycles = 300;
  localparam int         MaxPrints  = 50;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = REG_KEY_SEP;
  logic [ByteW-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic [KindW-1:0]     m_axis_tuser;
  logic                 m_axis_tlast;

  key_value_escape_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder copy: registers and parser state
  logic [7:0] key_sep    = KeySepRst;
  logic [7:0] pair_sep   = PairSepRst;
  logic [7:0] esc_char   = EscRst;
  logic       dec_in_value = 1'b0;
  logic       dec_pair_start = 1'b1;
  logic       dec_reject = 1'b0;
  esc_e       dec_esc    = ESC_NONE;
  logic [3:0] dec_hi     = '0;

  logic [7:0] encoded_q[$];
  dec_res_t   decoded_q[$];
  dec_res_t   beat_res[$];

  int n_fail = 0;
  int n_beats_in = 0;
  int n_results = 0;
  int n_records = 0;
  int n_errors = 0;
  int n_queued = 0;

  logic in_took = 1'b0;
  logic idle_on = 1'b1;
  logic hold_go = 1'b0;
  logic rx_blocked = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;

  // {bad, nibble}; a bad digit leaves nibble 0xF
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] d;
    d = 8'hFF;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
    return {d == 8'hFF, d[3:0]};
  endfunction

  function automatic logic [7:0] plain_escape(logic [7:0] c);
    case (c)
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      "0":     return 8'd0;
      default: return c;
    endcase
  endfunction

  task automatic add_res(kind_e k, logic [7:0] d, logic v);
    dec_res_t r;
    r.kind     = k;
    r.data     = (k == KIND_DATA) ? d : 8'd0;
    r.in_value = (k == KIND_DATA) ? v : 1'b0;
    r.last     = 1'b0;
    beat_res.push_back(r);
  endtask

  task automatic clear_parser();
    dec_in_value   = 1'b0;
    dec_pair_start = 1'b1;
    dec_esc        = ESC_NONE;
    dec_hi         = '0;
    dec_reject     = 1'b0;
  endtask

  task automatic decode_byte(logic [7:0] b);
    logic [4:0] hd;
    beat_res.delete();
    hd = hex_digit(b);
    if (dec_reject) begin
      if (b == EndByte) clear_parser();
    end else if (b == EndByte) begin
      // a pending escape is simply dropped
      if (dec_in_value) begin
        add_res(KIND_PAIR_DONE, 8'd0, 1'b0);
        add_res(KIND_RECORD_DONE, 8'd0, 1'b0);
      end else if (dec_pair_start) begin
        add_res(KIND_RECORD_DONE, 8'd0, 1'b0);
      end else begin
        add_res(KIND_ERROR, 8'd0, 1'b0);
      end
      clear_parser();
    end else if (dec_esc == ESC_START) begin
      if (b == HexIntro) begin
        dec_esc = ESC_HI;
      end else begin
        dec_esc = ESC_NONE;
        add_res(KIND_DATA, plain_escape(b), dec_in_value);
      end
    end else if (dec_esc == ESC_HI) begin
      dec_hi  = hd[3:0];
      dec_esc = ESC_LO;
    end else if (dec_esc == ESC_LO) begin
      dec_esc = ESC_NONE;
      add_res(KIND_DATA, hd[4] ? 8'hFF : {dec_hi, hd[3:0]}, dec_in_value);
    end else if (!dec_in_value) begin
      dec_pair_start = 1'b0;
      // reserved separator wins over the key separator and the escape
      if (b == pair_sep) begin
        add_res(KIND_ERROR, 8'd0, 1'b0);
        dec_reject = 1'b1;
      end else if (b == key_sep) begin
        dec_in_value = 1'b1;
        add_res(KIND_KEY_DONE, 8'd0, 1'b0);
      end else if (b == esc_char) begin
        dec_esc = ESC_START;
      end else begin
        add_res(KIND_DATA, b, 1'b0);
      end
    end else begin
      if (b == key_sep) begin
        add_res(KIND_ERROR, 8'd0, 1'b0);
        dec_reject = 1'b1;
      end else if (b == pair_sep) begin
        dec_in_value   = 1'b0;
        dec_pair_start = 1'b1;
        add_res(KIND_PAIR_DONE, 8'd0, 1'b0);
      end else if (b == esc_char) begin
        dec_esc = ESC_START;
      end else begin
        add_res(KIND_DATA, b, 1'b1);
      end
    end
    if (beat_res.size() > 0) beat_res[beat_res.size() - 1].last = 1'b1;
    foreach (beat_res[i]) decoded_q.push_back(beat_res[i]);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    n_fail++;
    // keep the log bounded on a badly broken block
    if (n_fail <= MaxPrints)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // output check and input prediction, both at the rising edge
  always @(posedge clk_i) begin : mon
    dec_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          report_mismatch("beat with nothing pending", m_axis_tdata, 16'd0);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("kind", 16'(m_axis_tuser), 16'(want.kind));
          if (m_axis_tdata[7:0] !== want.data)
            report_mismatch("byte", 16'(m_axis_tdata[7:0]), 16'(want.data));
          if (m_axis_tdata[8] !== want.in_value)
            report_mismatch("in_value", 16'(m_axis_tdata[8]), 16'(want.in_value));
          if (m_axis_tdata[15:9] !== 7'd0)
            report_mismatch("tdata pad", 16'(m_axis_tdata[15:9]), 16'd0);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 16'(m_axis_tlast), 16'(want.last));
          if (want.kind == KIND_RECORD_DONE) n_records++;
          if (want.kind == KIND_ERROR) n_errors++;
        end
      end
      in_took <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        n_beats_in++;
        decode_byte(s_axis_tdata);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !in_took)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (encoded_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= encoded_q.pop_front();
        tx_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_blocked) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_gap = pick_gap();
      m_axis_tready <= (rx_gap == 0);
      if (rx_gap > 0) rx_gap--;
    end
  end

  // long receiver hold-off so the result queue fills and input backs up
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_blocked = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_blocked = 1'b0;
  end

  task automatic put(logic [7:0] b);
    encoded_q.push_back(b);
    n_queued++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == key_sep || c == pair_sep || c == esc_char);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int idx;
    logic [7:0] c;
    if ($urandom_range(0, 99) < 15) return 8'($urandom_range(1, 255));
    idx = $urandom_range(0, 21);
    if (idx < 10) c = "0" + 8'(idx);
    else if (idx < 16) c = "a" + 8'(idx - 10);
    else c = "A" + 8'(idx - 16);
    return c;
  endfunction

  task automatic add_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (esc_char == 8'd0 || r < 6) begin
      put(plain_char());
    end else if (r < 8) begin
      put(esc_char);
      case ($urandom_range(0, 5))
        0: c = "n";
        1: c = "r";
        2: c = "t";
        3: c = "0";
        default: begin
          do c = 8'($urandom_range(1, 255));
          while (c == HexIntro);
        end
      endcase
      put(c);
    end else begin
      put(esc_char);
      put(HexIntro);
      put(hex_char());
      put(hex_char());
    end
  endtask

  task automatic add_chars(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) add_char();
  endtask

  task automatic gen_record();
    int n_pairs;
    n_pairs = $urandom_range(0, 3);
    for (int p = 0; p < n_pairs; p++) begin
      add_chars(0, 4);
      put(key_sep);
      add_chars(0, 5);
      if (p < n_pairs - 1 || $urandom_range(0, 2) == 0) put(pair_sep);
    end
    put(EndByte);
  endtask

  task automatic gen_broken();
    int n;
    case ($urandom_range(0, 4))
      0: begin
        n = $urandom_range(1, 12);
        repeat (n) put(8'($urandom_range(0, 255)));
      end
      1: begin
        add_chars(0, 3);
        put(pair_sep);
        n = $urandom_range(0, 4);
        repeat (n) put(8'($urandom_range(1, 255)));
      end
      2: begin
        add_chars(0, 3);
        put(key_sep);
        add_chars(0, 3);
        put(key_sep);
      end
      3: begin
        // escape cut short by the end of the string
        add_chars(0, 2);
        if ($urandom_range(0, 1)) begin
          put(key_sep);
          add_chars(0, 2);
        end
        if (esc_char != 8'd0) begin
          put(esc_char);
          if ($urandom_range(0, 2) != 0) begin
            put(HexIntro);
            if ($urandom_range(0, 1)) put(hex_char());
          end
        end
      end
      default: add_chars(1, 4);
    endcase
    put(EndByte);
  endtask

  task automatic gen_mix(int target);
    int start;
    start = n_queued;
    while (n_queued - start < target) begin
      if ($urandom_range(0, 3) != 0) gen_record();
      else gen_broken();
    end
  endtask

  task automatic wait_idle();
    while (encoded_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_KEY_SEP:  key_sep  = v;
      REG_PAIR_SEP: pair_sep = v;
      default:      esc_char = v;
    endcase
  endtask

  task automatic set_regs(logic [7:0] k, logic [7:0] p, logic [7:0] e);
    write_reg(REG_KEY_SEP, k);
    write_reg(REG_PAIR_SEP, p);
    write_reg(REG_ESC, e);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, bad hex digits, escaped zero, end in value, truncated
    // escape, empty record, reserved separator in a key
    encoded_q = {8'hFF, "=", 8'h01, ";", EndByte,
                 esc_char, "x", "g", "1", esc_char, "x", "1", "z", "=",
                 esc_char, "0", esc_char, "q", EndByte,
                 "=", esc_char, "x", EndByte,
                 EndByte,
                 "k", ";", "z", EndByte};
    n_queued = encoded_q.size();
    wait_idle();

    idle_on = 1'b0;
    hold_go = 1'b1;
    gen_mix(150);
    wait_idle();
    idle_on = 1'b1;
    gen_mix(100);
    wait_idle();

    set_regs(8'd255, 8'd1, 8'd128);
    gen_mix(110);
    wait_idle();

    // one byte for all three roles: separator priority
    set_regs(8'd100, 8'd100, 8'd100);
    gen_mix(60);
    wait_idle();

    // zero escape register never matches
    set_regs(8'd1, 8'd255, 8'd0);
    gen_mix(60);
    wait_idle();

    repeat (2) begin
      set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               8'($urandom_range(1, 255)));
      gen_mix(70);
      wait_idle();
    end

    set_regs(KeySepRst, PairSepRst, EscRst);
    gen_mix(100);
    wait_idle();

    $display("Ran %0d input beats, checked %0d results (%0d records closed, %0d errors).",
             n_beats_in, n_results, n_records, n_errors);
    $display("Settings: reset values, both extremes, shared byte, zero escape, random.");
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", decoded_q.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
